// ===== design/sqv_pkg.sv =====
// ----------------------------------------------------------------------------
// sqv_pkg
// Shared types and constants for the sprite quad vertex expander: field
// widths, register map, corner codes, controller states and the command
// bundle between controller and datapath.
// ----------------------------------------------------------------------------
package sqv_pkg;

	// Field widths
	localparam int POS_W    = 24;
	localparam int SCL_W    = 16;
	localparam int ROT_W    = 16;
	localparam int HALF_W   = 23;
	localparam int SRC_W    = 16;
	localparam int COLOR_W  = 32;
	localparam int MAXQ_W   = 13;
	localparam int SLOT_W   = 14;
	localparam int CORNER_W = 2;

	// Largest limit the max_quads register can express
	localparam int MAXQ_REG_MAX = (1 << MAXQ_W) - 1;

	// Internal arithmetic widths
	localparam int SH_W   = 32; // scaled half size, Q.8
	localparam int PROD_W = 48; // half size times sine or cosine, Q.22
	localparam int SUM_W  = 50; // sum of two products
	localparam int RND_W  = 36; // rotated offset rounded to Q.8
	localparam int EXT_W  = 37; // position plus offset before saturation

	// Stream payload widths
	localparam int S_TDATA_W = 2 * POS_W + 2 * SCL_W + 2 * ROT_W;
	localparam int M_TDATA_W = 2 * POS_W + 2 * SRC_W + COLOR_W + SLOT_W + CORNER_W;
	localparam int M_TUSER_W = 2;

	// Configuration port
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	localparam logic [2:0] REG_HALF_WIDTH   = 3'd0;
	localparam logic [2:0] REG_HALF_HEIGHT  = 3'd1;
	localparam logic [2:0] REG_SRC_LEFT     = 3'd2;
	localparam logic [2:0] REG_SRC_TOP      = 3'd3;
	localparam logic [2:0] REG_SRC_RIGHT    = 3'd4;
	localparam logic [2:0] REG_SRC_BOTTOM   = 3'd5;
	localparam logic [2:0] REG_VERTEX_COLOR = 3'd6;
	localparam logic [2:0] REG_MAX_QUADS    = 3'd7;

	// Corner codes, in emission order
	localparam logic [CORNER_W-1:0] CORNER_TL = 2'd0;
	localparam logic [CORNER_W-1:0] CORNER_TR = 2'd1;
	localparam logic [CORNER_W-1:0] CORNER_BR = 2'd2;
	localparam logic [CORNER_W-1:0] CORNER_BL = 2'd3;

	typedef struct packed {
		logic [HALF_W-1:0]  half_width;
		logic [HALF_W-1:0]  half_height;
		logic [SRC_W-1:0]   src_left;
		logic [SRC_W-1:0]   src_top;
		logic [SRC_W-1:0]   src_right;
		logic [SRC_W-1:0]   src_bottom;
		logic [COLOR_W-1:0] vertex_color;
		logic [MAXQ_W-1:0]  max_quads;
	} cfg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCALE,
		ST_ROTATE,
		ST_ROUND,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic                load;
		logic                scale;
		logic                rotate;
		logic                round;
		logic                emit;
		logic [CORNER_W-1:0] corner;
	} dp_cmd_t;

	typedef struct packed {
		logic out_free;
	} dp_status_t;

endpackage

// ===== design/sqv_regs.sv =====
// ----------------------------------------------------------------------------
// sqv_regs
// Configuration register file behind a simple APB-style port. Registers sit
// at byte address 4*index; reads return the stored value.
// ----------------------------------------------------------------------------
module sqv_regs import sqv_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t       cfg_q;
	logic       wr_en;
	logic [2:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign reg_idx = paddr[4:2];
	assign cfg     = cfg_q;

	// Write the addressed register on a completed write request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.half_width   <= '0;
			cfg_q.half_height  <= '0;
			cfg_q.src_left     <= '0;
			cfg_q.src_top      <= '0;
			cfg_q.src_right    <= '0;
			cfg_q.src_bottom   <= '0;
			cfg_q.vertex_color <= '1;
			cfg_q.max_quads    <= MAXQ_W'(4096);
		end else if (wr_en) begin
			case (reg_idx)
				REG_HALF_WIDTH:   cfg_q.half_width   <= pwdata[HALF_W-1:0];
				REG_HALF_HEIGHT:  cfg_q.half_height  <= pwdata[HALF_W-1:0];
				REG_SRC_LEFT:     cfg_q.src_left     <= pwdata[SRC_W-1:0];
				REG_SRC_TOP:      cfg_q.src_top      <= pwdata[SRC_W-1:0];
				REG_SRC_RIGHT:    cfg_q.src_right    <= pwdata[SRC_W-1:0];
				REG_SRC_BOTTOM:   cfg_q.src_bottom   <= pwdata[SRC_W-1:0];
				REG_VERTEX_COLOR: cfg_q.vertex_color <= pwdata[COLOR_W-1:0];
				REG_MAX_QUADS:    cfg_q.max_quads    <= pwdata[MAXQ_W-1:0];
				default: ;
			endcase
		end
	end

	// Read back the addressed register
	always_comb begin
		case (reg_idx)
			REG_HALF_WIDTH:   prdata = DATA_W'(cfg_q.half_width);
			REG_HALF_HEIGHT:  prdata = DATA_W'(cfg_q.half_height);
			REG_SRC_LEFT:     prdata = DATA_W'(cfg_q.src_left);
			REG_SRC_TOP:      prdata = DATA_W'(cfg_q.src_top);
			REG_SRC_RIGHT:    prdata = DATA_W'(cfg_q.src_right);
			REG_SRC_BOTTOM:   prdata = DATA_W'(cfg_q.src_bottom);
			REG_VERTEX_COLOR: prdata = DATA_W'(cfg_q.vertex_color);
			REG_MAX_QUADS:    prdata = DATA_W'(cfg_q.max_quads);
			default:          prdata = '0;
		endcase
	end

endmodule

// ===== design/sqv_ctrl.sv =====
// ----------------------------------------------------------------------------
// sqv_ctrl
// Controller: steps one sprite through scale, rotate and round, then walks
// the four corners into the result register as it frees up.
// ----------------------------------------------------------------------------
module sqv_ctrl import sqv_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	state_t              state_q;
	state_t              state_d;
	logic [CORNER_W-1:0] corner_q;

	// State and corner counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			corner_q <= CORNER_TL;
		end else begin
			state_q <= state_d;
			if (state_q == ST_EMIT && status.out_free) begin
				corner_q <= corner_q + CORNER_W'(1);
			end
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_SCALE;
				end
			end
			ST_SCALE:  state_d = ST_ROTATE;
			ST_ROTATE: state_d = ST_ROUND;
			ST_ROUND:  state_d = ST_EMIT;
			ST_EMIT: begin
				if (status.out_free && corner_q == CORNER_BL) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Commands to the datapath
	always_comb begin
		in_ready   = 1'b0;
		cmd        = '0;
		cmd.corner = corner_q;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_SCALE:  cmd.scale  = 1'b1;
			ST_ROTATE: cmd.rotate = 1'b1;
			ST_ROUND:  cmd.round  = 1'b1;
			ST_EMIT:   cmd.emit   = status.out_free;
			default: ;
		endcase
	end

endmodule

// ===== design/sqv_dp.sv =====
// ----------------------------------------------------------------------------
// sqv_dp
// Datapath: input capture, draw buffer fill count, scaled half size, rotation
// products, per-corner rounding and the saturating output register.
// ----------------------------------------------------------------------------
module sqv_dp import sqv_pkg::*; #(
	parameter int MAX_QUADS = 4096
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cfg_t                 cfg,
	input  dp_cmd_t              cmd,
	output dp_status_t           status,
	input  logic [S_TDATA_W-1:0] s_tdata,
	input  logic                 s_tlast,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,
	output logic [M_TUSER_W-1:0] m_tuser,
	output logic                 m_tlast
);

	localparam int LIM_MAX = (MAX_QUADS < MAXQ_REG_MAX) ? MAX_QUADS : MAXQ_REG_MAX;
	localparam int QW      = $clog2(LIM_MAX + 1);

	localparam logic signed [EXT_W-1:0] VMAX_E = EXT_W'(8388607);
	localparam logic signed [EXT_W-1:0] VMIN_E = -EXT_W'(8388608);

	// Captured sprite
	logic signed [POS_W-1:0] px_q, py_q;
	logic signed [SCL_W-1:0] scx_q, scy_q;
	logic signed [ROT_W-1:0] sin_q, cos_q;
	logic                    last_q;
	logic [QW-1:0]           base_q;
	logic                    opens_q;

	// Fill count and limit
	logic [QW-1:0] quads_q;
	logic [QW-1:0] lim;
	logic [QW-1:0] q_eff;

	// Arithmetic stages
	logic signed [SH_W-1:0]   shw_q, shh_q;
	logic signed [39:0]       pw, ph;
	logic signed [PROD_W-1:0] a_q, b_q, c_q, d_q;
	logic signed [RND_W-1:0]  rx_q [4];
	logic signed [RND_W-1:0]  ry_q [4];
	logic signed [RND_W-1:0]  rx_d [4];
	logic signed [RND_W-1:0]  ry_d [4];
	logic signed [SUM_W-1:0]  ax, bx, cx, dx, sum_x, sum_y;
	logic [CORNER_W-1:0]      k;

	// Output stage
	logic signed [EXT_W-1:0] vx_e, vy_e;
	logic [POS_W-1:0]        vx_sat, vy_sat;
	logic                    out_valid_q;
	logic [POS_W-1:0]        vx_q, vy_q;
	logic [SRC_W-1:0]        u_q, v_q;
	logic [COLOR_W-1:0]      color_q;
	logic [SLOT_W-1:0]       slot_q;
	logic [CORNER_W-1:0]     corner_q;
	logic                    start_q, end_q, lastc_q;

	// Clamp the quad limit into one through the build maximum
	always_comb begin
		if (cfg.max_quads == '0) begin
			lim = QW'(1);
		end else if (32'(cfg.max_quads) > LIM_MAX) begin
			lim = QW'(LIM_MAX);
		end else begin
			lim = QW'(cfg.max_quads);
		end
		q_eff = (quads_q >= lim) ? '0 : quads_q;
	end

	// Track quads in the draw buffer; flush on full or after the batch end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quads_q <= '0;
		end else if (cmd.load) begin
			quads_q <= s_tlast ? '0 : q_eff + QW'(1);
		end
	end

	// Capture the sprite
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			px_q    <= s_tdata[23:0];
			py_q    <= s_tdata[47:24];
			scx_q   <= s_tdata[63:48];
			scy_q   <= s_tdata[79:64];
			sin_q   <= s_tdata[95:80];
			cos_q   <= s_tdata[111:96];
			last_q  <= s_tlast;
			base_q  <= q_eff;
			opens_q <= (q_eff == '0);
		end
	end

	// Scale the half size, rounding half up to Q.8
	assign pw = $signed({1'b0, cfg.half_width}) * scx_q;
	assign ph = $signed({1'b0, cfg.half_height}) * scy_q;

	always_ff @(posedge clk) begin
		if (cmd.scale) begin
			shw_q <= SH_W'((pw + 40'sd128) >>> 8);
			shh_q <= SH_W'((ph + 40'sd128) >>> 8);
		end
	end

	// Rotation products
	always_ff @(posedge clk) begin
		if (cmd.rotate) begin
			a_q <= shw_q * cos_q;
			b_q <= shh_q * sin_q;
			c_q <= shw_q * sin_q;
			d_q <= shh_q * cos_q;
		end
	end

	// Per-corner rotated offsets, rounded half up from Q.22 to Q.8
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			k  = CORNER_W'(i);
			ax = SUM_W'(a_q);
			bx = SUM_W'(b_q);
			cx = SUM_W'(c_q);
			dx = SUM_W'(d_q);
			if (k == CORNER_TL || k == CORNER_BL) begin
				ax = -ax;
				cx = -cx;
			end
			if (k == CORNER_TL || k == CORNER_TR) begin
				bx = -bx;
				dx = -dx;
			end
			sum_x   = ax - bx;
			sum_y   = cx + dx;
			rx_d[i] = RND_W'((sum_x + SUM_W'(8192)) >>> 14);
			ry_d[i] = RND_W'((sum_y + SUM_W'(8192)) >>> 14);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.round) begin
			for (int i = 0; i < 4; i++) begin
				rx_q[i] <= rx_d[i];
				ry_q[i] <= ry_d[i];
			end
		end
	end

	// Translate and saturate the selected corner
	always_comb begin
		vx_e = EXT_W'(px_q) + EXT_W'(rx_q[cmd.corner]);
		vy_e = EXT_W'(py_q) + EXT_W'(ry_q[cmd.corner]);
		if (vx_e > VMAX_E) begin
			vx_sat = POS_W'(VMAX_E);
		end else if (vx_e < VMIN_E) begin
			vx_sat = POS_W'(VMIN_E);
		end else begin
			vx_sat = vx_e[POS_W-1:0];
		end
		if (vy_e > VMAX_E) begin
			vy_sat = POS_W'(VMAX_E);
		end else if (vy_e < VMIN_E) begin
			vy_sat = POS_W'(VMIN_E);
		end else begin
			vy_sat = vy_e[POS_W-1:0];
		end
	end

	// Result valid: set on emit, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			vx_q     <= vx_sat;
			vy_q     <= vy_sat;
			u_q      <= (cmd.corner == CORNER_TL || cmd.corner == CORNER_BL) ?
				cfg.src_left : cfg.src_right;
			v_q      <= (cmd.corner == CORNER_TL || cmd.corner == CORNER_TR) ?
				cfg.src_top : cfg.src_bottom;
			color_q  <= cfg.vertex_color;
			slot_q   <= SLOT_W'({base_q, cmd.corner});
			corner_q <= cmd.corner;
			start_q  <= (cmd.corner == CORNER_TL) && opens_q;
			end_q    <= (cmd.corner == CORNER_BL) && last_q;
			lastc_q  <= (cmd.corner == CORNER_BL);
		end
	end

	assign status.out_free = !out_valid_q || m_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {corner_q, slot_q, color_q, v_q, u_q, vy_q, vx_q};
	assign m_tuser  = {end_q, start_q};
	assign m_tlast  = lastc_q;

endmodule

// ===== design/sprite_quad_vertex_expander_top.sv =====
// Flow: an accepted sprite passes through the scale multiply, rotation multiplies
// and corner rounding, then its four vertices go through the single result register,
// one per cycle while the output is not stalled. A new sprite is accepted only once
// the last vertex of the previous one has entered the result register.
// Reset: arst_n clears the controller, fill count and result valid, and returns the registers to their defaults.
// ----------------------------------------------------------------------------
// sprite_quad_vertex_expander_top
// Expands one sprite transform into four quad corner vertices with texture
// coordinates, colour, vertex slot and draw-call boundary flags.
// ----------------------------------------------------------------------------
module sprite_quad_vertex_expander_top import sqv_pkg::*; #(
	parameter int MAX_QUADS = 4096
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// pos_x[23:0], pos_y[47:24], scale_x[63:48], scale_y[79:64],
	// sin_rot[95:80], cos_rot[111:96]
	input  logic [S_TDATA_W-1:0] s_axis_tdata,
	input  logic                 s_axis_tlast,   // batch_last
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	// vertex_x[23:0], vertex_y[47:24], tex_u[63:48], tex_v[79:64],
	// color_out[111:80], vertex_slot[125:112], corner_id[127:126]
	output logic [M_TDATA_W-1:0] m_axis_tdata,
	// draw_start[0], draw_end[1]
	output logic [M_TUSER_W-1:0] m_axis_tuser,
	output logic                 m_axis_tlast,   // last_corner
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [ADDR_W-1:0]    paddr,
	input  logic [DATA_W-1:0]    pwdata,
	output logic [DATA_W-1:0]    prdata,
	output logic                 pready
);

	cfg_t       cfg;
	dp_cmd_t    cmd;
	dp_status_t status;

	// Configuration registers
	sqv_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Sequencer
	sqv_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.status   (status),
		.cmd      (cmd)
	);

	// Arithmetic and result register
	sqv_dp #(
		.MAX_QUADS (MAX_QUADS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.cmd      (cmd),
		.status   (status),
		.s_tdata  (s_axis_tdata),
		.s_tlast  (s_axis_tlast),
		.m_tvalid (m_axis_tvalid),
		.m_tready (m_axis_tready),
		.m_tdata  (m_axis_tdata),
		.m_tuser  (m_axis_tuser),
		.m_tlast  (m_axis_tlast)
	);

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sprite quad vertex expander. Sprite requests
// are driven from a queue, each accepted sprite is expanded by a local
// predictor into its four expected corner vertices, and every vertex leaving
// the block is checked field by field against the oldest expectation.
// Registers are rewritten between phases, once the block has drained.
// ----------------------------------------------------------------------------
module tb_top;
	import sqv_pkg::*;

	localparam int MAX_Q = 4096;
	localparam int COORD_MAX = 8388607;
	localparam int COORD_MIN = -8388608;

	typedef struct {
		logic signed [POS_W-1:0] pos_x;
		logic signed [POS_W-1:0] pos_y;
		logic signed [SCL_W-1:0] scale_x;
		logic signed [SCL_W-1:0] scale_y;
		logic signed [ROT_W-1:0] sin_rot;
		logic signed [ROT_W-1:0] cos_rot;
		logic                    batch_last;
	} sprite_t;

	typedef struct {
		logic [POS_W-1:0]    vx;
		logic [POS_W-1:0]    vy;
		logic [SRC_W-1:0]    u;
		logic [SRC_W-1:0]    v;
		logic [COLOR_W-1:0]  color;
		logic [SLOT_W-1:0]   slot;
		logic [CORNER_W-1:0] corner;
		logic                draw_start;
		logic                draw_end;
		logic                last_corner;
	} vertex_t;

	logic                 clk;
	logic                 arst_n = 1'b0;
	// pos_x, pos_y, scale_x, scale_y, sin_rot, cos_rot (lowest bits first)
	logic [S_TDATA_W-1:0] s_axis_tdata = '0;
	logic                 s_axis_tlast = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	// vertex_x, vertex_y, tex_u, tex_v, color_out, vertex_slot, corner_id
	logic [M_TDATA_W-1:0] m_axis_tdata;
	// draw_start, draw_end
	logic [M_TUSER_W-1:0] m_axis_tuser;
	logic                 m_axis_tlast;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic                 psel = 1'b0;
	logic                 penable = 1'b0;
	logic                 pwrite = 1'b0;
	logic [ADDR_W-1:0]    paddr = '0;
	logic [DATA_W-1:0]    pwdata = '0;
	logic [DATA_W-1:0]    prdata;
	logic                 pready;

	sprite_t          sprite_q[$];
	vertex_t          vertex_q[$];
	sprite_t          cur_sprite;
	vertex_t          want;
	cfg_t             shadow;
	logic [MAXQ_W-1:0] fill_count;
	int               mismatches = 0;
	int               src_gap = 0;
	int               sink_hold = 0;
	int               gap_pct = 0;
	int               stall_pct = 0;

	sprite_quad_vertex_expander_top #(
		.MAX_QUADS(MAX_Q)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tlast(s_axis_tlast),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Round half up: floor((v + 2^(sh-1)) / 2^sh)
	function automatic longint rnd_shift(longint v, int sh);
		return (v + (longint'(1) << (sh - 1))) >>> sh;
	endfunction

	function automatic logic [POS_W-1:0] sat_coord(longint v);
		if (v > COORD_MAX)
			return POS_W'(COORD_MAX);
		if (v < COORD_MIN)
			return POS_W'(COORD_MIN);
		return POS_W'(v);
	endfunction

	// Expand one accepted sprite into its four expected corners
	function automatic void expand_sprite(sprite_t sp);
		longint lim;
		longint shw;
		longint shh;
		longint lx;
		longint ly;
		longint rx;
		longint ry;
		logic opens;
		logic left;
		logic top;
		logic [CORNER_W-1:0] c;
		vertex_t vtx;
		lim = longint'(shadow.max_quads);
		if (lim == 0)
			lim = 1;
		if (lim > MAX_Q)
			lim = MAX_Q;
		// flush a full buffer before the sprite
		if (fill_count >= lim)
			fill_count = '0;
		opens = (fill_count == 0);
		shw = rnd_shift(longint'(shadow.half_width) * longint'(sp.scale_x), 8);
		shh = rnd_shift(longint'(shadow.half_height) * longint'(sp.scale_y), 8);
		for (int k = 0; k < 4; k++) begin
			c = CORNER_W'(k);
			left = (c == CORNER_TL) || (c == CORNER_BL);
			top = (c == CORNER_TL) || (c == CORNER_TR);
			lx = left ? -shw : shw;
			ly = top ? -shh : shh;
			rx = rnd_shift(lx * longint'(sp.cos_rot) - ly * longint'(sp.sin_rot), 14);
			ry = rnd_shift(lx * longint'(sp.sin_rot) + ly * longint'(sp.cos_rot), 14);
			vtx.vx = sat_coord(longint'(sp.pos_x) + rx);
			vtx.vy = sat_coord(longint'(sp.pos_y) + ry);
			vtx.u = left ? shadow.src_left : shadow.src_right;
			vtx.v = top ? shadow.src_top : shadow.src_bottom;
			vtx.color = shadow.vertex_color;
			vtx.slot = SLOT_W'({fill_count, c});
			vtx.corner = c;
			vtx.draw_start = (c == CORNER_TL) && opens;
			vtx.draw_end = (c == CORNER_BL) && sp.batch_last;
			vtx.last_corner = (c == CORNER_BL);
			vertex_q = {vertex_q, vtx};
		end
		// a batch end flushes the buffer after the sprite
		if (sp.batch_last)
			fill_count = '0;
		else
			fill_count = fill_count + 1'b1;
	endfunction

	task automatic report_mismatch(string msg);
		$display("[%0t] vertex check failed: %s", $realtime, msg);
		mismatches++;
	endtask

	task automatic check_field(string name, logic [31:0] got, logic [31:0] exp_val);
		if (got !== exp_val)
			report_mismatch($sformatf("%s got %h want %h", name, got, exp_val));
	endtask

	// Sprite driver: present queued requests, advance on acceptance
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			src_gap = 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				expand_sprite(cur_sprite);
			if (!s_axis_tvalid || s_axis_tready) begin
				if (src_gap > 0) begin
					src_gap--;
					s_axis_tvalid <= 1'b0;
				end else if (sprite_q.size() > 0) begin
					cur_sprite = sprite_q.pop_front();
					s_axis_tdata <= {cur_sprite.cos_rot, cur_sprite.sin_rot,
						cur_sprite.scale_y, cur_sprite.scale_x,
						cur_sprite.pos_y, cur_sprite.pos_x};
					s_axis_tlast <= cur_sprite.batch_last;
					s_axis_tvalid <= 1'b1;
					if ($urandom_range(0, 99) < gap_pct)
						src_gap = $urandom_range(1, 11);
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Vertex sink: stall in random bursts
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			sink_hold = 0;
		end else if (sink_hold > 0) begin
			sink_hold--;
			m_axis_tready <= 1'b0;
		end else if ($urandom_range(0, 99) < stall_pct) begin
			sink_hold = $urandom_range(0, 10);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// Vertex monitor: compare each accepted vertex with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (vertex_q.size() == 0) begin
				report_mismatch("vertex with no sprite pending");
			end else begin
				want = vertex_q.pop_front();
				check_field("vertex_x", 32'(m_axis_tdata[23:0]), 32'(want.vx));
				check_field("vertex_y", 32'(m_axis_tdata[47:24]), 32'(want.vy));
				check_field("tex_u", 32'(m_axis_tdata[63:48]), 32'(want.u));
				check_field("tex_v", 32'(m_axis_tdata[79:64]), 32'(want.v));
				check_field("color_out", m_axis_tdata[111:80], want.color);
				check_field("vertex_slot", 32'(m_axis_tdata[125:112]), 32'(want.slot));
				check_field("corner_id", 32'(m_axis_tdata[127:126]), 32'(want.corner));
				check_field("draw_start", 32'(m_axis_tuser[0]), 32'(want.draw_start));
				check_field("draw_end", 32'(m_axis_tuser[1]), 32'(want.draw_end));
				check_field("last_corner", 32'(m_axis_tlast), 32'(want.last_corner));
			end
		end
	end

	// Register write: setup cycle, then access cycle
	task automatic cfg_write(logic [2:0] idx, logic [DATA_W-1:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_HALF_WIDTH:   shadow.half_width = val[HALF_W-1:0];
			REG_HALF_HEIGHT:  shadow.half_height = val[HALF_W-1:0];
			REG_SRC_LEFT:     shadow.src_left = val[SRC_W-1:0];
			REG_SRC_TOP:      shadow.src_top = val[SRC_W-1:0];
			REG_SRC_RIGHT:    shadow.src_right = val[SRC_W-1:0];
			REG_SRC_BOTTOM:   shadow.src_bottom = val[SRC_W-1:0];
			REG_VERTEX_COLOR: shadow.vertex_color = val;
			REG_MAX_QUADS:    shadow.max_quads = val[MAXQ_W-1:0];
			default: ;
		endcase
	endtask

	task automatic set_regs(int hw, int hh, int l, int t, int r, int b,
			logic [31:0] color, int mq);
		cfg_write(REG_HALF_WIDTH, hw);
		cfg_write(REG_HALF_HEIGHT, hh);
		cfg_write(REG_SRC_LEFT, l);
		cfg_write(REG_SRC_TOP, t);
		cfg_write(REG_SRC_RIGHT, r);
		cfg_write(REG_SRC_BOTTOM, b);
		cfg_write(REG_VERTEX_COLOR, color);
		cfg_write(REG_MAX_QUADS, mq);
		@(negedge clk);
	endtask

	// Hold until every queued sprite is accepted and every vertex has left
	task automatic drain();
		do
			@(negedge clk);
		while (sprite_q.size() != 0 || s_axis_tvalid || vertex_q.size() != 0);
		repeat (8) @(posedge clk);
	endtask

	function automatic void mk(int px, int py, int sx, int sy, int s, int c, int l);
		sprite_t sp;
		sp.pos_x = POS_W'(px);
		sp.pos_y = POS_W'(py);
		sp.scale_x = SCL_W'(sx);
		sp.scale_y = SCL_W'(sy);
		sp.sin_rot = ROT_W'(s);
		sp.cos_rot = ROT_W'(c);
		sp.batch_last = (l != 0);
		sprite_q = {sprite_q, sp};
	endfunction

	function automatic logic [POS_W-1:0] rand_pos();
		logic b;
		b = 1'($urandom_range(0, 1));
		// near a rail a third of the time, to reach saturation
		if ($urandom_range(0, 2) == 0)
			return {b, {7{~b}}, 16'($urandom)};
		return POS_W'($urandom);
	endfunction

	function automatic logic [SCL_W-1:0] rand_scale();
		if ($urandom_range(0, 9) < 7)
			return SCL_W'($urandom_range(0, 2048) - 1024);
		return SCL_W'($urandom);
	endfunction

	function automatic logic [ROT_W-1:0] rand_rot();
		if ($urandom_range(0, 99) < 85)
			return ROT_W'($urandom_range(0, 32768) - 16384);
		return ROT_W'($urandom);
	endfunction

	task automatic queue_random(int n);
		sprite_t sp;
		repeat (n) begin
			sp.pos_x = rand_pos();
			sp.pos_y = rand_pos();
			sp.scale_x = rand_scale();
			sp.scale_y = rand_scale();
			sp.sin_rot = rand_rot();
			sp.cos_rot = rand_rot();
			sp.batch_last = ($urandom_range(0, 7) == 0);
			sprite_q = {sprite_q, sp};
		end
	endtask

	initial begin
		int mq_list[6];
		shadow = '0;
		shadow.vertex_color = '1;
		shadow.max_quads = MAXQ_W'(MAX_Q);
		fill_count = '0;
		mq_list = '{3, MAXQ_REG_MAX, 1, 2, MAX_Q, 5};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Reset defaults, no idling
		@(negedge clk);
		queue_random(4);
		drain();

		// Largest half size, zero limit acting as one
		gap_pct = 30;
		stall_pct = 30;
		set_regs(COORD_MAX, COORD_MAX, 0, 0, 32'hFFFF, 32'hFFFF, 32'h0, 0);
		mk(0, 0, 256, 256, 0, 16384, 0);
		mk(COORD_MAX, COORD_MAX, 32767, 32767, 0, 16384, 0);
		mk(COORD_MIN, COORD_MIN, -32768, -32768, 0, 16384, 0);
		mk(0, 0, 0, 0, 16384, 0, 1);
		mk(COORD_MAX, COORD_MIN, -256, 256, -16384, 0, 0);
		mk(0, 0, 1, 1, 0, -16384, 1);
		mk(0, 0, 256, -256, -32768, 32767, 0);
		mk(COORD_MIN, COORD_MAX, 32767, -32768, 32767, -32768, 1);
		drain();

		// Small odd half size for rounding ties, limit of two for full buffers
		set_regs(32'h801, 32'h7FF, 32'h0123, 32'h0456, 32'hFEDC, 32'hBA98,
			32'h80FF00FF, 2);
		mk(0, 0, 256, 256, 0, 16384, 0);
		mk(0, 0, 128, 128, 0, 16384, 0);
		mk(1000, -1000, 256, 256, 11585, 11585, 0);
		mk(100, -100, -128, 384, -11585, 11585, 0);
		mk(-5000, 5000, 384, -128, 11585, -11585, 1);
		mk(0, 0, 1, -1, 16384, 0, 0);
		mk(0, 0, -1, 1, -16384, 0, 1);
		mk(COORD_MAX, 0, 256, 256, 0, 16384, 1);
		mk(COORD_MIN, 0, 256, 256, 0, -16384, 0);
		mk(0, COORD_MAX, 32767, 256, 16384, 0, 0);
		mk(0, COORD_MIN, 256, 32767, 16384, 16384, 0);
		mk(-1, -1, -32768, -32768, -16384, -16384, 1);
		drain();

		// Random phases; the last one runs without idling
		for (int p = 0; p < 6; p++) begin
			gap_pct = (p == 5) ? 0 : (p % 3) * 25;
			stall_pct = (p == 5) ? 0 : ((p + 1) % 3) * 25;
			set_regs(
				(p == 1) ? $urandom_range(0, COORD_MAX) : $urandom_range(0, 1 << 16),
				(p == 1) ? $urandom_range(0, COORD_MAX) : $urandom_range(0, 1 << 16),
				$urandom_range(0, 32'hFFFF), $urandom_range(0, 32'hFFFF),
				$urandom_range(0, 32'hFFFF), $urandom_range(0, 32'hFFFF),
				$urandom, mq_list[p]);
			queue_random(70);
			drain();
		end

		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

	// Watchdog
	initial begin
		#400000;
		$display("tb_top: errors");
		$finish;
	end

endmodule

// ===== sprite_quad_vertex_expander_top.f =====
design/sqv_pkg.sv
design/sqv_regs.sv
design/sqv_ctrl.sv
design/sqv_dp.sv
design/sprite_quad_vertex_expander_top.sv
sim/tb_top.sv
